### design/lsps_pkg.sv
// Shared types, widths and constants of the line-sensor PID steering core.
// No dependencies; imported by every module of the core.
package lsps_pkg;

  localparam int MAX_SENSORS      = 8;
  localparam int SENSOR_COUNT_DEF = 8;
  localparam int SAMPLE_BITS_DEF  = 10;

  localparam int THR_W      = 10;
  localparam int GAIN_W     = 16;
  localparam int DRIVE_W    = 8;
  localparam int LIMIT_W    = 4;
  localparam int RUN_W      = 4;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;

  localparam int ERR_W    = 6;
  localparam int DERR_W   = ERR_W + 1;
  localparam int INTEG_W  = 17;
  localparam int ISUM_W   = INTEG_W + 1;
  localparam int PID_W    = 16;
  localparam int DSUM_W   = PID_W + 2;
  localparam int P_TERM_W = GAIN_W + 1 + ERR_W;
  localparam int I_TERM_W = GAIN_W + 1 + INTEG_W;
  localparam int D_TERM_W = GAIN_W + 1 + DERR_W;
  localparam int SUM_W    = I_TERM_W + 2;
  localparam int FRAC_W   = 8;

  typedef logic signed [ERR_W-1:0] err_t;

  localparam err_t WEIGHTS [MAX_SENSORS] = '{
    err_t'(-7), err_t'(-5), err_t'(-3), err_t'(1),
    err_t'(1),  err_t'(3),  err_t'(5),  err_t'(7)
  };

  localparam err_t ERR_STRAIGHT_LIM = err_t'(4);
  localparam err_t ERR_TURN_LIM     = err_t'(6);

  localparam logic [THR_W-1:0]   BLACK_THR_RST    = THR_W'(800);
  localparam logic [THR_W-1:0]   WHITE_THR_RST    = THR_W'(750);
  localparam logic [GAIN_W-1:0]  GAIN_P_RST       = GAIN_W'(1856);
  localparam logic [GAIN_W-1:0]  GAIN_I_RST       = GAIN_W'(320);
  localparam logic [GAIN_W-1:0]  GAIN_D_RST       = GAIN_W'(192);
  localparam logic [DRIVE_W-1:0] BASE_SPEED_RST   = DRIVE_W'(255);
  localparam logic [LIMIT_W-1:0] FINISH_LIMIT_RST = LIMIT_W'(5);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BLACK_THR    = 3'd0,
    CFG_WHITE_THR    = 3'd1,
    CFG_GAIN_P       = 3'd2,
    CFG_GAIN_I       = 3'd3,
    CFG_GAIN_D       = 3'd4,
    CFG_BASE_SPEED   = 3'd5,
    CFG_FINISH_LIMIT = 3'd6
  } cfg_idx_t;

  typedef enum logic [1:0] {
    MODE_STRAIGHT   = 2'd0,
    MODE_TURN_LEFT  = 2'd1,
    MODE_TURN_RIGHT = 2'd2,
    MODE_HOLD       = 2'd3
  } steer_mode_t;

  typedef struct packed {
    logic [THR_W-1:0]   black_thr;
    logic [THR_W-1:0]   white_thr;
    logic [GAIN_W-1:0]  gain_p;
    logic [GAIN_W-1:0]  gain_i;
    logic [GAIN_W-1:0]  gain_d;
    logic [DRIVE_W-1:0] base_speed;
    logic [LIMIT_W-1:0] finish_limit;
  } cfg_t;

  typedef struct packed {
    logic signed [ERR_W-1:0]   err;
    logic signed [DERR_W-1:0]  derr;
    logic signed [INTEG_W-1:0] integ;
    logic [MAX_SENSORS-1:0]    mask;
    logic                      finish;
  } cls_t;

  typedef struct packed {
    logic signed [ERR_W-1:0]    err;
    logic [MAX_SENSORS-1:0]     mask;
    logic                       finish;
    logic signed [P_TERM_W-1:0] p_term;
    logic signed [I_TERM_W-1:0] i_term;
    logic signed [D_TERM_W-1:0] d_term;
  } prod_t;

  typedef struct packed {
    logic signed [ERR_W-1:0] err;
    logic [MAX_SENSORS-1:0]  mask;
    logic                    finish;
    logic signed [PID_W-1:0] pid;
  } pid_t;

endpackage

### design/lsps_classify.sv
// Sensor classification with hysteresis, weighted line error, saturating integral
// and all-black run counter. Depends on lsps_pkg.
module lsps_classify import lsps_pkg::*; #(
  parameter int SENSOR_COUNT = SENSOR_COUNT_DEF,
  parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cfg_t                   cfg,
  input  logic                   vld_i,
  output logic                   rdy_o,
  input  logic [SAMPLE_BITS-1:0] sample_i [MAX_SENSORS],
  output logic                   vld_o,
  input  logic                   rdy_i,
  output cls_t                   cls_o
);

  localparam int USED  = (SENSOR_COUNT > MAX_SENSORS) ? MAX_SENSORS : SENSOR_COUNT;
  localparam int CMP_W = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;
  localparam logic [MAX_SENSORS-1:0] USED_MASK = MAX_SENSORS'((1 << USED) - 1);

  logic                      vld_r;
  cls_t                      cls_r;
  logic [MAX_SENSORS-1:0]    blk_r, blk_nxt;
  logic signed [INTEG_W-1:0] integ_r, integ_nxt;
  logic signed [ERR_W-1:0]   prev_r, err_nxt;
  logic [RUN_W-1:0]          run_r, run_nxt;
  logic signed [ISUM_W-1:0]  isum;
  logic signed [DERR_W-1:0]  derr;
  logic [CMP_W-1:0]          s_ext;
  logic                      all_blk;
  logic                      take;

  assign rdy_o = !vld_r || rdy_i;
  assign take  = vld_i && rdy_o;

  always_comb begin
    err_nxt = '0;
    s_ext   = '0;
    for (int i = 0; i < MAX_SENSORS; i++) begin
      s_ext = CMP_W'(sample_i[i]);
      if (i >= USED) begin
        blk_nxt[i] = 1'b0;
      end else if (s_ext >= CMP_W'(cfg.black_thr)) begin
        blk_nxt[i] = 1'b1;
      end else if (s_ext <= CMP_W'(cfg.white_thr)) begin
        blk_nxt[i] = 1'b0;
      end else begin
        blk_nxt[i] = blk_r[i];
      end
      if (blk_nxt[i]) begin
        err_nxt = err_nxt + WEIGHTS[i];
      end
    end
  end

  always_comb begin
    isum = ISUM_W'(integ_r) + ISUM_W'(err_nxt);
    if (isum[ISUM_W-1] != isum[ISUM_W-2]) begin
      integ_nxt = isum[ISUM_W-1] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                 : {1'b0, {(INTEG_W-1){1'b1}}};
    end else begin
      integ_nxt = isum[INTEG_W-1:0];
    end
  end

  assign derr    = DERR_W'(err_nxt) - DERR_W'(prev_r);
  assign all_blk = (blk_nxt & USED_MASK) == USED_MASK;

  always_comb begin
    if (!all_blk) begin
      run_nxt = '0;
    end else if (&run_r) begin
      run_nxt = run_r;
    end else begin
      run_nxt = run_r + RUN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= 1'b0;
      blk_r   <= '0;
      integ_r <= '0;
      prev_r  <= '0;
      run_r   <= '0;
    end else begin
      if (rdy_o) begin
        vld_r <= vld_i;
      end
      if (take) begin
        blk_r   <= blk_nxt;
        integ_r <= integ_nxt;
        prev_r  <= err_nxt;
        run_r   <= run_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cls_r.err    <= err_nxt;
      cls_r.derr   <= derr;
      cls_r.integ  <= integ_nxt;
      cls_r.mask   <= blk_nxt;
      cls_r.finish <= run_nxt >= cfg.finish_limit;
    end
  end

  assign vld_o = vld_r;
  assign cls_o = cls_r;

endmodule

### design/lsps_pid.sv
// PID output: gain products in one stage, sum, truncation toward zero and
// saturation in the next. Depends on lsps_pkg.
module lsps_pid import lsps_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  cfg_t cfg,
  input  logic vld_i,
  output logic rdy_o,
  input  cls_t cls_i,
  output logic vld_o,
  input  logic rdy_i,
  output pid_t pid_o
);

  localparam int Q_W = SUM_W - FRAC_W;
  localparam logic signed [Q_W-1:0] Q_MAX = Q_W'((2 ** (PID_W - 1)) - 1);
  localparam logic signed [Q_W-1:0] Q_MIN = Q_W'(-(2 ** (PID_W - 1)));

  logic                       prd_vld_r, pid_vld_r;
  logic                       prd_rdy, pid_rdy;
  prod_t                      prd_r;
  pid_t                       pid_r;
  logic signed [GAIN_W:0]     kp_s, ki_s, kd_s;
  logic signed [P_TERM_W-1:0] p_mul;
  logic signed [I_TERM_W-1:0] i_mul;
  logic signed [D_TERM_W-1:0] d_mul;
  logic signed [SUM_W-1:0]    sum;
  logic signed [Q_W-1:0]      q_floor, q_trunc;
  logic                       adj;
  logic signed [PID_W-1:0]    pid_nxt;

  assign pid_rdy = !pid_vld_r || rdy_i;
  assign prd_rdy = !prd_vld_r || pid_rdy;
  assign rdy_o   = prd_rdy;

  assign kp_s  = $signed({1'b0, cfg.gain_p});
  assign ki_s  = $signed({1'b0, cfg.gain_i});
  assign kd_s  = $signed({1'b0, cfg.gain_d});
  assign p_mul = kp_s * cls_i.err;
  assign i_mul = ki_s * cls_i.integ;
  assign d_mul = kd_s * cls_i.derr;

  assign sum     = SUM_W'(prd_r.p_term) + SUM_W'(prd_r.i_term) + SUM_W'(prd_r.d_term);
  assign q_floor = $signed(sum[SUM_W-1:FRAC_W]);
  assign adj     = sum[SUM_W-1] && (|sum[FRAC_W-1:0]);
  assign q_trunc = q_floor + $signed({{(Q_W-1){1'b0}}, adj});

  always_comb begin
    if (q_trunc > Q_MAX) begin
      pid_nxt = {1'b0, {(PID_W-1){1'b1}}};
    end else if (q_trunc < Q_MIN) begin
      pid_nxt = {1'b1, {(PID_W-1){1'b0}}};
    end else begin
      pid_nxt = q_trunc[PID_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prd_vld_r <= 1'b0;
      pid_vld_r <= 1'b0;
    end else begin
      if (prd_rdy) begin
        prd_vld_r <= vld_i;
      end
      if (pid_rdy) begin
        pid_vld_r <= prd_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (vld_i && prd_rdy) begin
      prd_r.err    <= cls_i.err;
      prd_r.mask   <= cls_i.mask;
      prd_r.finish <= cls_i.finish;
      prd_r.p_term <= p_mul;
      prd_r.i_term <= i_mul;
      prd_r.d_term <= d_mul;
    end
    if (prd_vld_r && pid_rdy) begin
      pid_r.err    <= prd_r.err;
      pid_r.mask   <= prd_r.mask;
      pid_r.finish <= prd_r.finish;
      pid_r.pid    <= pid_nxt;
    end
  end

  assign vld_o = pid_vld_r;
  assign pid_o = pid_r;

endmodule

### design/lsps_drive.sv
// Band rules, drive clamping, held command and the result register.
// Depends on lsps_pkg.
module lsps_drive import lsps_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cfg_t                    cfg,
  input  logic                    vld_i,
  output logic                    rdy_o,
  input  pid_t                    pid_i,
  output logic                    vld_o,
  input  logic                    rdy_i,
  output logic [DRIVE_W-1:0]      left_o,
  output logic [DRIVE_W-1:0]      right_o,
  output logic [DRIVE_W-1:0]      mean_o,
  output steer_mode_t             mode_o,
  output logic signed [ERR_W-1:0] err_o,
  output logic signed [PID_W-1:0] pid_o,
  output logic [MAX_SENSORS-1:0]  mask_o,
  output logic                    finish_o
);

  function automatic logic [DRIVE_W-1:0] clamp_drive(input logic signed [DSUM_W-1:0] v);
    logic [DRIVE_W-1:0] res;
    if (v[DSUM_W-1]) begin
      res = '0;
    end else if (|v[DSUM_W-2:DRIVE_W]) begin
      res = '1;
    end else begin
      res = v[DRIVE_W-1:0];
    end
    return res;
  endfunction

  logic                     vld_r, take;
  logic [DRIVE_W-1:0]       held_left_r, held_right_r, held_mean_r;
  logic [DRIVE_W-1:0]       left_r, right_r, mean_r;
  steer_mode_t              mode_r;
  logic signed [ERR_W-1:0]  err_r;
  logic signed [PID_W-1:0]  pid_r;
  logic [MAX_SENSORS-1:0]   mask_r;
  logic                     finish_r;
  logic signed [DSUM_W-1:0] base_s, pid_s, plus, minus;
  logic [DRIVE_W-1:0]       left_nxt, right_nxt, mean_nxt;
  logic [DRIVE_W:0]         mean_sum;
  steer_mode_t              mode_nxt;

  assign rdy_o = !vld_r || rdy_i;
  assign take  = vld_i && rdy_o;

  assign base_s = $signed({{(DSUM_W-DRIVE_W){1'b0}}, cfg.base_speed});
  assign pid_s  = DSUM_W'(pid_i.pid);
  assign plus   = base_s + pid_s;
  assign minus  = base_s - pid_s;

  always_comb begin
    if (pid_i.err != '0 && pid_i.err >= -ERR_STRAIGHT_LIM && pid_i.err <= ERR_STRAIGHT_LIM) begin
      mode_nxt  = MODE_STRAIGHT;
      left_nxt  = '1;
      right_nxt = '1;
    end else if (pid_i.err <= -ERR_TURN_LIM) begin
      mode_nxt  = MODE_TURN_LEFT;
      left_nxt  = clamp_drive(minus);
      right_nxt = clamp_drive(plus);
    end else if (pid_i.err >= ERR_TURN_LIM) begin
      mode_nxt  = MODE_TURN_RIGHT;
      left_nxt  = clamp_drive(plus);
      right_nxt = clamp_drive(minus);
    end else begin
      mode_nxt  = MODE_HOLD;
      left_nxt  = held_left_r;
      right_nxt = held_right_r;
    end
    mean_sum = {1'b0, left_nxt} + {1'b0, right_nxt};
    mean_nxt = (mode_nxt == MODE_HOLD) ? held_mean_r : mean_sum[DRIVE_W:1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r        <= 1'b0;
      held_left_r  <= '0;
      held_right_r <= '0;
      held_mean_r  <= '0;
    end else begin
      if (rdy_o) begin
        vld_r <= vld_i;
      end
      if (take && mode_nxt != MODE_HOLD) begin
        held_left_r  <= left_nxt;
        held_right_r <= right_nxt;
        held_mean_r  <= mean_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      left_r   <= left_nxt;
      right_r  <= right_nxt;
      mean_r   <= mean_nxt;
      mode_r   <= mode_nxt;
      err_r    <= pid_i.err;
      pid_r    <= pid_i.pid;
      mask_r   <= pid_i.mask;
      finish_r <= pid_i.finish;
    end
  end

  assign vld_o    = vld_r;
  assign left_o   = left_r;
  assign right_o  = right_r;
  assign mean_o   = mean_r;
  assign mode_o   = mode_r;
  assign err_o    = err_r;
  assign pid_o    = pid_r;
  assign mask_o   = mask_r;
  assign finish_o = finish_r;

endmodule

### design/line_sensor_pid_steering_core.sv
// Line-sensor PID steering core: input register, classify, PID products, PID sum,
// band rules and result register. Depends on lsps_pkg, lsps_classify, lsps_pid, lsps_drive.
// An item passes five register stages: input, classify, PID products, PID sum, result.
// Throughput: one item per cycle while out_stall is low; every stage advances when its successor has room.
// Reset (synchronous, rst_n low): clears all valids, classes to white, integral, previous
// error, run count and held drives; configuration registers return to their defaults.
module line_sensor_pid_steering_core import lsps_pkg::*; #(
  parameter int SENSOR_COUNT = SENSOR_COUNT_DEF,
  parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_write_en,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [SAMPLE_BITS-1:0]  in_sample_0,
  input  logic [SAMPLE_BITS-1:0]  in_sample_1,
  input  logic [SAMPLE_BITS-1:0]  in_sample_2,
  input  logic [SAMPLE_BITS-1:0]  in_sample_3,
  input  logic [SAMPLE_BITS-1:0]  in_sample_4,
  input  logic [SAMPLE_BITS-1:0]  in_sample_5,
  input  logic [SAMPLE_BITS-1:0]  in_sample_6,
  input  logic [SAMPLE_BITS-1:0]  in_sample_7,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [DRIVE_W-1:0]      out_left_drive,
  output logic [DRIVE_W-1:0]      out_right_drive,
  output logic [DRIVE_W-1:0]      out_mean_drive,
  output logic [1:0]              out_steer_mode,
  output logic signed [ERR_W-1:0] out_line_error,
  output logic signed [PID_W-1:0] out_pid_value,
  output logic [MAX_SENSORS-1:0]  out_black_mask,
  output logic                    out_finish_flag
);

  cfg_t                   cfg_r;
  logic                   smp_vld_r;
  logic [SAMPLE_BITS-1:0] smp_r [MAX_SENSORS];
  logic                   smp_rdy, cls_rdy, cls_vld, pid_rdy, pid_vld, drv_rdy;
  cls_t                   cls;
  pid_t                   pid;
  steer_mode_t            mode;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.black_thr    <= BLACK_THR_RST;
      cfg_r.white_thr    <= WHITE_THR_RST;
      cfg_r.gain_p       <= GAIN_P_RST;
      cfg_r.gain_i       <= GAIN_I_RST;
      cfg_r.gain_d       <= GAIN_D_RST;
      cfg_r.base_speed   <= BASE_SPEED_RST;
      cfg_r.finish_limit <= FINISH_LIMIT_RST;
    end else if (cfg_write_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_BLACK_THR:    cfg_r.black_thr    <= cfg_data[THR_W-1:0];
        CFG_WHITE_THR:    cfg_r.white_thr    <= cfg_data[THR_W-1:0];
        CFG_GAIN_P:       cfg_r.gain_p       <= cfg_data[GAIN_W-1:0];
        CFG_GAIN_I:       cfg_r.gain_i       <= cfg_data[GAIN_W-1:0];
        CFG_GAIN_D:       cfg_r.gain_d       <= cfg_data[GAIN_W-1:0];
        CFG_BASE_SPEED:   cfg_r.base_speed   <= cfg_data[DRIVE_W-1:0];
        CFG_FINISH_LIMIT: cfg_r.finish_limit <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  assign smp_rdy  = !smp_vld_r || cls_rdy;
  assign in_stall = !smp_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smp_vld_r <= 1'b0;
    end else if (smp_rdy) begin
      smp_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && smp_rdy) begin
      smp_r[0] <= in_sample_0;
      smp_r[1] <= in_sample_1;
      smp_r[2] <= in_sample_2;
      smp_r[3] <= in_sample_3;
      smp_r[4] <= in_sample_4;
      smp_r[5] <= in_sample_5;
      smp_r[6] <= in_sample_6;
      smp_r[7] <= in_sample_7;
    end
  end

  lsps_classify #(
    .SENSOR_COUNT (SENSOR_COUNT),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_classify (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .vld_i    (smp_vld_r),
    .rdy_o    (cls_rdy),
    .sample_i (smp_r),
    .vld_o    (cls_vld),
    .rdy_i    (pid_rdy),
    .cls_o    (cls)
  );

  lsps_pid u_pid (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_r),
    .vld_i (cls_vld),
    .rdy_o (pid_rdy),
    .cls_i (cls),
    .vld_o (pid_vld),
    .rdy_i (drv_rdy),
    .pid_o (pid)
  );

  lsps_drive u_drive (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .vld_i    (pid_vld),
    .rdy_o    (drv_rdy),
    .pid_i    (pid),
    .vld_o    (out_valid),
    .rdy_i    (!out_stall),
    .left_o   (out_left_drive),
    .right_o  (out_right_drive),
    .mean_o   (out_mean_drive),
    .mode_o   (mode),
    .err_o    (out_line_error),
    .pid_o    (out_pid_value),
    .mask_o   (out_black_mask),
    .finish_o (out_finish_flag)
  );

  assign out_steer_mode = mode;

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for line_sensor_pid_steering_core: directed sample sets, then random
// line tracks, finish runs, hysteresis and noise, each drive result checked by a predictor or a typed result.
// Depends on lsps_pkg and the core RTL.
module tb_top;
  import lsps_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int INTEG_HI = 65535;
  localparam int INTEG_LO = -65536;
  localparam int LANE_WEIGHT [8] = '{-7, -5, -3, 1, 1, 3, 5, 7};

  typedef logic [7:0][9:0] sample_set_t;

  typedef struct packed {
    logic [7:0]         left;
    logic [7:0]         right;
    logic [7:0]         mean;
    steer_mode_t        mode;
    logic signed [5:0]  err;
    logic signed [15:0] pid;
    logic [7:0]         mask;
    logic               finish;
  } steer_result_t;

  typedef struct packed {
    logic [9:0]  black_thr;
    logic [9:0]  white_thr;
    logic [15:0] kp;
    logic [15:0] ki;
    logic [15:0] kd;
    logic [7:0]  base;
    logic [3:0]  limit;
  } reg_set_t;

  typedef struct packed {
    bit            setup;
    bit            known;
    sample_set_t   smp;
    steer_result_t typed;
    reg_set_t      regs;
  } plan_row_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_write_en = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [9:0]              in_sample_0 = '0;
  logic [9:0]              in_sample_1 = '0;
  logic [9:0]              in_sample_2 = '0;
  logic [9:0]              in_sample_3 = '0;
  logic [9:0]              in_sample_4 = '0;
  logic [9:0]              in_sample_5 = '0;
  logic [9:0]              in_sample_6 = '0;
  logic [9:0]              in_sample_7 = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [DRIVE_W-1:0]      out_left_drive;
  logic [DRIVE_W-1:0]      out_right_drive;
  logic [DRIVE_W-1:0]      out_mean_drive;
  logic [1:0]              out_steer_mode;
  logic signed [ERR_W-1:0] out_line_error;
  logic signed [PID_W-1:0] out_pid_value;
  logic [MAX_SENSORS-1:0]  out_black_mask;
  logic                    out_finish_flag;

  line_sensor_pid_steering_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_write_en    (cfg_write_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sample_0     (in_sample_0),
    .in_sample_1     (in_sample_1),
    .in_sample_2     (in_sample_2),
    .in_sample_3     (in_sample_3),
    .in_sample_4     (in_sample_4),
    .in_sample_5     (in_sample_5),
    .in_sample_6     (in_sample_6),
    .in_sample_7     (in_sample_7),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_left_drive  (out_left_drive),
    .out_right_drive (out_right_drive),
    .out_mean_drive  (out_mean_drive),
    .out_steer_mode  (out_steer_mode),
    .out_line_error  (out_line_error),
    .out_pid_value   (out_pid_value),
    .out_black_mask  (out_black_mask),
    .out_finish_flag (out_finish_flag)
  );

  // predictor copy of registers and state
  int thr_black, thr_white, gain_p, gain_i, gain_d, base_lvl, run_limit;
  logic [7:0] lane_black;
  int integ_acc, prev_err, black_run, held_l, held_r, held_m;

  steer_result_t drive_expect[$];
  plan_row_t     plan[$];
  int  items_sent = 0;
  int  results_seen = 0;
  int  setups = 0;
  int  fail_count = 0;
  int  cycle_count = 0;
  int  hold_cnt = 0;
  bit  idle_on = 1'b0;

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic int drive_clamp(input longint v);
    if (v < 0) return 0;
    if (v > 255) return 255;
    return int'(v);
  endfunction

  function automatic steer_result_t steer_predict(input sample_set_t smp);
    steer_result_t r;
    int i, err, nblack, lv, rv;
    longint sum, pidv;
    logic [7:0] mask;
    err = 0;
    nblack = 0;
    mask = '0;
    for (i = 0; i < 8; i++) begin
      if (int'(smp[i]) >= thr_black) lane_black[i] = 1'b1;
      else if (int'(smp[i]) <= thr_white) lane_black[i] = 1'b0;
      if (lane_black[i]) begin
        err += LANE_WEIGHT[i];
        mask[i] = 1'b1;
        nblack++;
      end
    end
    integ_acc += err;
    if (integ_acc > INTEG_HI) integ_acc = INTEG_HI;
    if (integ_acc < INTEG_LO) integ_acc = INTEG_LO;
    sum = longint'(gain_p) * err + longint'(gain_i) * integ_acc
        + longint'(gain_d) * (err - prev_err);
    pidv = sum / 256;
    if (pidv > 32767) pidv = 32767;
    if (pidv < -32768) pidv = -32768;
    prev_err = err;
    if (err >= -4 && err <= 4 && err != 0) begin
      lv = 255;
      rv = 255;
      r.mode = MODE_STRAIGHT;
    end else if (err <= -6) begin
      lv = drive_clamp(base_lvl - pidv);
      rv = drive_clamp(base_lvl + pidv);
      r.mode = MODE_TURN_LEFT;
    end else if (err >= 6) begin
      lv = drive_clamp(base_lvl + pidv);
      rv = drive_clamp(base_lvl - pidv);
      r.mode = MODE_TURN_RIGHT;
    end else begin
      lv = held_l;
      rv = held_r;
      r.mode = MODE_HOLD;
    end
    if (r.mode != MODE_HOLD) begin
      held_l = lv;
      held_r = rv;
      held_m = (lv + rv) >> 1;
    end
    if (nblack == 8) begin
      if (black_run < 15) black_run++;
    end else begin
      black_run = 0;
    end
    r.left = 8'(lv);
    r.right = 8'(rv);
    r.mean = 8'(held_m);
    r.err = 6'(err);
    r.pid = 16'(pidv);
    r.mask = mask;
    r.finish = (black_run >= run_limit);
    return r;
  endfunction

  function automatic steer_result_t res(input int l, input int rt, input int m,
                                        input steer_mode_t md, input int e, input int p,
                                        input int mk, input bit f);
    steer_result_t r;
    r.left = 8'(l);
    r.right = 8'(rt);
    r.mean = 8'(m);
    r.mode = md;
    r.err = 6'(e);
    r.pid = 16'(p);
    r.mask = 8'(mk);
    r.finish = f;
    return r;
  endfunction

  function automatic reg_set_t regs(input int bt, input int wt, input int kp, input int ki,
                                    input int kd, input int base, input int limit);
    reg_set_t s;
    s.black_thr = 10'(bt);
    s.white_thr = 10'(wt);
    s.kp = 16'(kp);
    s.ki = 16'(ki);
    s.kd = 16'(kd);
    s.base = 8'(base);
    s.limit = 4'(limit);
    return s;
  endfunction

  function automatic int corner_pick(input int lo, input int hi);
    case ($urandom_range(7, 0))
      0: return lo;
      1: return hi;
      default: return $urandom_range(hi, lo);
    endcase
  endfunction

  function automatic reg_set_t pick_regs(input int ph);
    int bt, wt;
    if (ph == 0) return regs(0, 0, 0, 0, 0, 0, 0);
    if (ph == 1) return regs(1023, 1023, 65535, 65535, 65535, 255, 15);
    bt = ($urandom_range(7, 0) == 0) ? corner_pick(0, 1023) : $urandom_range(980, 400);
    wt = ($urandom_range(7, 0) == 0) ? corner_pick(0, 1023) : bt - $urandom_range(250, 1);
    return regs(bt, wt,
                ($urandom_range(3, 0) == 0) ? corner_pick(0, 65535) : $urandom_range(4095, 0),
                ($urandom_range(3, 0) == 0) ? corner_pick(0, 65535) : $urandom_range(1023, 0),
                ($urandom_range(3, 0) == 0) ? corner_pick(0, 65535) : $urandom_range(2047, 0),
                corner_pick(0, 255), $urandom_range(15, 0));
  endfunction

  function automatic sample_set_t fixed_samples(input logic [7:0] lanes, input int hi,
                                                input int lo);
    sample_set_t smp;
    int i;
    for (i = 0; i < 8; i++) smp[i] = lanes[i] ? 10'(hi) : 10'(lo);
    return smp;
  endfunction

  // black lanes at or above the black threshold, fuzz lanes between thresholds, rest white
  function automatic sample_set_t shape_samples(input logic [7:0] lanes,
                                                input logic [7:0] fuzz);
    sample_set_t smp;
    int i, white_top;
    white_top = (thr_black == 0) ? 0 :
                ((thr_white < thr_black) ? thr_white : thr_black - 1);
    for (i = 0; i < 8; i++) begin
      if (fuzz[i] && thr_black > thr_white + 1)
        smp[i] = 10'($urandom_range(thr_black - 1, thr_white + 1));
      else if (lanes[i])
        smp[i] = 10'($urandom_range(1023, thr_black));
      else
        smp[i] = 10'($urandom_range(white_top, 0));
    end
    return smp;
  endfunction

  function automatic void plan_feed(input sample_set_t smp, input bit known,
                                    input steer_result_t typed);
    plan_row_t row;
    row = '0;
    row.known = known;
    row.smp = smp;
    row.typed = typed;
    plan.push_back(row);
  endfunction

  function automatic void plan_setup(input reg_set_t s);
    plan_row_t row;
    row = '0;
    row.setup = 1'b1;
    row.regs = s;
    plan.push_back(row);
  endfunction

  function automatic void check_field(input string name, input longint want,
                                      input longint got);
    if (want != got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  task automatic feed_samples(input sample_set_t smp, input bit known,
                              input steer_result_t typed);
    int gap;
    steer_result_t pred;
    gap = idle_on ? $urandom_range(9, 0) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    {in_sample_7, in_sample_6, in_sample_5, in_sample_4,
     in_sample_3, in_sample_2, in_sample_1, in_sample_0} <= smp;
    do @(posedge clk); while (in_stall);
    pred = steer_predict(smp);
    drive_expect.push_back(known ? typed : pred);
    items_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (drive_expect.size() != 0);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [15:0] val);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      CFG_BLACK_THR:    thr_black = int'(val[9:0]);
      CFG_WHITE_THR:    thr_white = int'(val[9:0]);
      CFG_GAIN_P:       gain_p = int'(val);
      CFG_GAIN_I:       gain_i = int'(val);
      CFG_GAIN_D:       gain_d = int'(val);
      CFG_BASE_SPEED:   base_lvl = int'(val[7:0]);
      CFG_FINISH_LIMIT: run_limit = int'(val[3:0]);
      default: ;
    endcase
  endtask

  task automatic apply_regs(input reg_set_t s);
    settle();
    write_reg(CFG_BLACK_THR, 16'(s.black_thr));
    write_reg(CFG_WHITE_THR, 16'(s.white_thr));
    write_reg(CFG_GAIN_P, s.kp);
    write_reg(CFG_GAIN_I, s.ki);
    write_reg(CFG_GAIN_D, s.kd);
    write_reg(CFG_BASE_SPEED, 16'(s.base));
    write_reg(CFG_FINISH_LIMIT, 16'(s.limit));
    cfg_write_en <= 1'b0;
    setups++;
  endtask

  always @(posedge clk) begin : drain_results
    steer_result_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (drive_expect.size() == 0) begin
          fail_count++;
          $display("%0t: drive result with no item pending, expected none, got mask %0h",
                   $time, out_black_mask);
        end else begin
          want = drive_expect.pop_front();
          check_field("left_drive", want.left, out_left_drive);
          check_field("right_drive", want.right, out_right_drive);
          check_field("mean_drive", want.mean, out_mean_drive);
          check_field("steer_mode", want.mode, out_steer_mode);
          check_field("line_error", want.err, out_line_error);
          check_field("pid_value", want.pid, out_pid_value);
          check_field("black_mask", want.mask, out_black_mask);
          check_field("finish_flag", want.finish, out_finish_flag);
        end
        hold_cnt = idle_on ? $urandom_range(9, 0) : 0;
      end else if (hold_cnt > 0) begin
        hold_cnt--;
      end
      out_stall <= (hold_cnt > 0);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: run exceeded %0d cycles with %0d results pending",
               $time, CYCLE_LIMIT, drive_expect.size());
      $display("tb_top NOT OK");
      $finish;
    end
  end

  initial begin
    int ph, kind, pos, wid, len, i, target;
    logic [7:0] lanes, fuzz;
    sample_set_t smp;

    thr_black = 800;
    thr_white = 750;
    gain_p = 1856;
    gain_i = 320;
    gain_d = 192;
    base_lvl = 255;
    run_limit = 5;
    lane_black = '0;
    integ_acc = 0;
    prev_err = 0;
    black_run = 0;
    held_l = 0;
    held_r = 0;
    held_m = 0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    plan_feed(fixed_samples(8'h00, 0, 0), 1'b1, res(0, 0, 0, MODE_HOLD, 0, 0, 8'h00, 0));
    plan_feed(fixed_samples(8'hFF, 1023, 0), 1'b0, '0);
    plan_feed(fixed_samples(8'h00, 775, 775), 1'b0, '0);
    plan_feed(fixed_samples(8'h01, 1023, 0), 1'b0, '0);
    plan_feed(fixed_samples(8'h80, 1023, 0), 1'b0, '0);
    plan_feed(fixed_samples(8'h03, 1023, 0), 1'b0, '0);
    plan_feed(fixed_samples(8'h02, 1023, 0), 1'b0, '0);
    plan_feed(fixed_samples(8'h40, 1023, 0), 1'b0, '0);
    plan_feed(fixed_samples(8'h08, 1023, 0), 1'b0, '0);
    plan_feed(fixed_samples(8'h07, 1023, 0), 1'b0, '0);
    plan_feed(fixed_samples(8'hF8, 1023, 0), 1'b0, '0);
    plan_feed(fixed_samples(8'h00, 1023, 750), 1'b0, '0);
    plan_feed(fixed_samples(8'hFF, 800, 0), 1'b0, '0);
    plan_setup(regs(800, 750, 0, 0, 0, 255, 5));
    plan_feed(fixed_samples(8'h01, 1023, 0), 1'b1,
              res(255, 255, 255, MODE_TURN_LEFT, -7, 0, 8'h01, 0));
    plan_setup(regs(800, 750, 0, 0, 0, 0, 5));
    plan_feed(fixed_samples(8'h80, 1023, 0), 1'b1,
              res(0, 0, 0, MODE_TURN_RIGHT, 7, 0, 8'h80, 0));
    plan_setup(regs(0, 1023, 65535, 65535, 65535, 128, 0));
    plan_feed(fixed_samples(8'h00, 1023, 0), 1'b0, '0);
    plan_feed(fixed_samples(8'h01, 1023, 500), 1'b0, '0);
    plan_setup(regs(1023, 0, 65535, 65535, 65535, 255, 15));
    plan_feed(fixed_samples(8'h01, 1023, 0), 1'b0, '0);
    plan_feed(fixed_samples(8'h00, 1022, 512), 1'b0, '0);
    plan_feed(fixed_samples(8'hFE, 1023, 0), 1'b0, '0);
    plan_feed(fixed_samples(8'hFF, 1023, 1023), 1'b0, '0);
    plan_feed(fixed_samples(8'h00, 0, 0), 1'b0, '0);

    idle_on = 1'b1;
    foreach (plan[k]) begin
      if (plan[k].setup) apply_regs(plan[k].regs);
      else feed_samples(plan[k].smp, plan[k].known, plan[k].typed);
    end

    for (ph = 0; ph < 10; ph++) begin
      apply_regs(pick_regs(ph));
      target = items_sent + 135;
      while (items_sent < target) begin
        idle_on = ($urandom_range(3, 0) != 0);
        kind = $urandom_range(99, 0);
        if (kind < 60) begin
          pos = $urandom_range(7, 0);
          wid = $urandom_range(3, 1);
          len = $urandom_range(12, 3);
          repeat (len) begin
            lanes = '0;
            for (i = 0; i < wid; i++) if (pos + i < 8) lanes[pos + i] = 1'b1;
            feed_samples(shape_samples(lanes, 8'h00), 1'b0, '0);
            pos = pos + $urandom_range(2, 0) - 1;
            if (pos < 0) pos = 0;
            if (pos > 7) pos = 7;
          end
        end else if (kind < 75) begin
          repeat ($urandom_range(17, 1)) feed_samples(shape_samples(8'hFF, 8'h00), 1'b0, '0);
        end else if (kind < 90) begin
          repeat ($urandom_range(4, 1)) begin
            for (i = 0; i < 8; i++) smp[i] = 10'($urandom);
            feed_samples(smp, 1'b0, '0);
          end
        end else begin
          repeat ($urandom_range(6, 2)) begin
            lanes = 8'($urandom);
            fuzz = 8'($urandom);
            feed_samples(shape_samples(lanes, fuzz), 1'b0, '0);
          end
        end
      end
    end

    settle();
    repeat (8) @(posedge clk);

    $display("%0d sample sets fed over %0d register settings, %0d drive results compared",
             items_sent, setups + 1, results_seen);
    $display("covered hysteresis, all band modes, drive clamping and finish runs");
    if (fail_count == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end

endmodule
